// File: rtl/bse_pkg.sv
// Shared types, codes and constant tables for the Bezier surface evaluator.
// No dependencies; imported by bse_in_if, bse_mul and the top level.
package bse_pkg;

  localparam int IDX_W    = 3;
  localparam int PARAM_W  = 17;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int BW_DEPTH = 2 ** IDX_W;

  localparam logic [PARAM_W-1:0] PARAM_ONE = 17'd65536;
  localparam logic [MUL_W-1:0]   W_ONE     = 32'h4000_0000;

  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_READ  = 3'd1,
    FN_POS   = 3'd2,
    FN_DU    = 3'd3,
    FN_DV    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_ERR = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_BMUL,
    S_BACC,
    S_BSCL,
    S_BSTO,
    S_TRDA,
    S_TRDB,
    S_TDIF,
    S_MLO,
    S_ALO,
    S_MHI,
    S_AHI,
    S_SCL,
    S_RND,
    S_DONE
  } state_t;

  // Binomial coefficient C(n,k) for n up to 4
  function automatic logic [2:0] binom(input logic [IDX_W-1:0] n, input logic [IDX_W-1:0] k);
    logic [2:0] r;
    r = 3'd0;
    if (k == 3'd0 || k == n) begin
      r = 3'd1;
    end else begin
      case (n)
        3'd2: r = 3'd2;
        3'd3: r = 3'd3;
        3'd4: r = (k == 3'd2) ? 3'd6 : 3'd4;
        default: r = 3'd0;
      endcase
    end
    if (k > n) begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

// File: rtl/bse_in_if.sv
// Request channel of the Bezier surface evaluator: handshake and payload.
// Depends on bse_pkg for field widths.
interface bse_in_if
  import bse_pkg::*;
#(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   func;
  logic [IDX_W-1:0]             u_index;
  logic [IDX_W-1:0]             v_index;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic [PARAM_W-1:0]           param_u;
  logic [PARAM_W-1:0]           param_v;

  modport source (output valid, func, u_index, v_index, point_x, point_y, point_z,
                  param_u, param_v, input ready);
  modport sink   (input valid, func, u_index, v_index, point_x, point_y, point_z,
                  param_u, param_v, output ready);
endinterface

// File: rtl/bse_out_if.sv
// Result channel of the Bezier surface evaluator: handshake and payload.
// Standalone; no package needed.
interface bse_out_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;

  modport source (output valid, status, out_x, out_y, out_z, input ready);
  modport sink   (input valid, status, out_x, out_y, out_z, output ready);
endinterface

// File: rtl/bse_cfg_if.sv
// Configuration write channel: carries the degree register write data.
// Standalone; no package needed.
interface bse_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] degree;

  modport source (output valid, degree, input ready);
  modport sink   (input valid, degree, output ready);
endinterface

// File: rtl/bezier_surface_evaluator.sv
// Tensor-product Bezier surface evaluator, top level.
// Depends on bse_pkg, bse_in_if, bse_out_if, bse_cfg_if, bse_ram and bse_mul.
//
// Usage:
//   cfg_ch writes the degree (2..MAX_DEGREE); a legal write clears all control
//   points to zero, other values are dropped. It is always ready and is meant to
//   be written only while no request is in flight.
//   in_ch takes one request at a time: write point, read point, or evaluate
//   position / u derivative / v derivative at (u,v). in_ch.ready is high only
//   while the sequencer is idle.
//   out_ch gives one result per request through an output register; the next
//   request is taken while that result waits for out_ch.ready.
// Sequencing:
//   write, error or unknown func go straight to the result; read reads RAM first.
//   evaluation: the Bernstein weights of both axes first, then each (i,j) term in
//   turn, (nu+1)*(nv+1) terms. Evaluation is paced by the single shared 32x32
//   multiplier, which computes every weight and every partial product in turn.
// Reset:
//   rst_n (synchronous, active low) sets degree to 3 (MAX_DEGREE if smaller) and marks
//   all control points as zero through per-point valid bits.
// Stall:
//   a result is held in the output register until taken; a next one waits in S_DONE.
module bezier_surface_evaluator
  import bse_pkg::*;
#(
  parameter int MAX_DEGREE = 4,
  parameter int COORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bse_in_if.sink     in_ch,
  bse_out_if.source  out_ch,
  bse_cfg_if.sink    cfg_ch
);
  localparam int STRIDE  = MAX_DEGREE + 1;
  localparam int NPTS    = STRIDE * STRIDE;
  localparam int AW      = $clog2(NPTS);
  localparam int WORD_W  = 3 * COORD_BITS;
  localparam int D_W     = COORD_BITS + 1;
  localparam int LO_BITS = (COORD_BITS + 1) / 2;
  localparam int HI_BITS = D_W - LO_BITS;
  localparam int ACC_W   = COORD_BITS + 44;
  localparam int RND_W   = ACC_W - 30;
  localparam logic [2:0] DEG_RST = (MAX_DEGREE < 3) ? 3'(MAX_DEGREE) : 3'd3;

  state_t state_r, state_nxt;

  logic [2:0]                degree_r;
  logic [NPTS-1:0]           valid_r;
  logic [2:0]                func_r;
  logic [PARAM_W-1:0]        pu_r, pv_r;
  logic                      axis_r;
  logic [IDX_W-1:0]          i_r, j_r, k_r;
  logic [MUL_W-1:0]          p_r;
  logic [MUL_W-1:0]          bu_r [BW_DEPTH];
  logic [MUL_W-1:0]          bv_r [BW_DEPTH];
  logic [MUL_W-1:0]          w_r;
  logic [WORD_W-1:0]         a_r;
  logic signed [D_W-1:0]     d_r [3];
  logic [1:0]                c_r;
  logic signed [ACC_W-1:0]   acc_r [3];
  logic                      rvalid_r;
  logic [1:0]                res_status_r;
  logic [COORD_BITS-1:0]     res_r [3];
  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic [COORD_BITS-1:0]     out_r [3];

  logic                      in_acc, cfg_acc, idx_ok;
  logic [AW-1:0]             in_addr, rd_addr, prim_addr, base_addr;
  logic                      ram_we;
  logic [WORD_W-1:0]         ram_wdata, ram_rdata, rd_word;
  logic [MUL_W-1:0]          op_a, op_b;
  logic [PROD_W-1:0]         prod_r;
  logic [IDX_W-1:0]          nu, nv, n_cur;
  logic [PARAM_W-1:0]        t_cur, s_cur;
  logic signed [D_W-1:0]     d_cur;
  logic                      d_neg;
  logic [D_W-1:0]            d_mag;
  logic signed [ACC_W-1:0]   term_lo, term_hi;
  logic [COORD_BITS-1:0]     rnd_res [3];
  logic [2:0]                rnd_sat;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cfg_acc   = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);

  assign idx_ok  = (in_ch.u_index <= degree_r) && (in_ch.v_index <= degree_r);
  assign in_addr = AW'(in_ch.v_index * STRIDE + in_ch.u_index);

  // degrees of the two Bernstein bases for the current mode
  assign nu    = degree_r - ((func_r == FN_DU) ? 3'd1 : 3'd0);
  assign nv    = degree_r - ((func_r == FN_DV) ? 3'd1 : 3'd0);
  assign n_cur = axis_r ? nv : nu;
  assign t_cur = axis_r ? pv_r : pu_r;
  assign s_cur = PARAM_ONE - t_cur;

  // term addresses: neighbor point for derivatives, base point otherwise
  assign base_addr = AW'(j_r * STRIDE + i_r);
  always_comb begin
    case (func_r)
      FN_DU:   prim_addr = AW'(j_r * STRIDE + i_r + 1);
      FN_DV:   prim_addr = AW'((j_r + 1) * STRIDE + i_r);
      default: prim_addr = base_addr;
    endcase
  end

  always_comb begin
    case (state_r)
      S_TRDA:  rd_addr = prim_addr;
      S_TRDB:  rd_addr = base_addr;
      default: rd_addr = in_addr;
    endcase
  end

  assign ram_we    = in_acc && (in_ch.func == FN_WRITE) && idx_ok;
  assign ram_wdata = {in_ch.point_z, in_ch.point_y, in_ch.point_x};

  bse_ram #(.WIDTH(WORD_W), .DEPTH(NPTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // points never written since reset or a degree write read as zero
  assign rd_word = rvalid_r ? ram_rdata : '0;

  // magnitude and sign of the current coordinate difference
  assign d_cur = d_r[c_r];
  assign d_neg = d_cur[D_W-1];
  assign d_mag = d_neg ? D_W'(-d_cur) : D_W'(d_cur);

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_BMUL: begin
        op_a = p_r;
        op_b = MUL_W'((k_r < i_r) ? t_cur : s_cur);
      end
      S_BSCL: begin
        op_a = p_r;
        op_b = MUL_W'(binom(n_cur, i_r));
      end
      S_TRDA: begin
        op_a = bu_r[i_r];
        op_b = bv_r[j_r];
      end
      S_MLO: begin
        op_a = MUL_W'(d_mag[LO_BITS-1:0]);
        op_b = w_r;
      end
      S_MHI: begin
        op_a = MUL_W'(d_mag[D_W-1:LO_BITS]);
        op_b = w_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  bse_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // signed partial products for the accumulator
  assign term_lo = d_neg ? -$signed(ACC_W'(prod_r)) : $signed(ACC_W'(prod_r));
  assign term_hi = d_neg ? -$signed(ACC_W'(prod_r) << LO_BITS)
                         : $signed(ACC_W'(prod_r) << LO_BITS);

  // round half up, drop 30 fraction bits, saturate each coordinate
  always_comb begin
    logic signed [ACC_W-1:0] sum;
    logic signed [RND_W-1:0] r;
    for (int c = 0; c < 3; c++) begin
      sum = acc_r[c] + $signed(ACC_W'(W_ONE >> 1));
      r   = RND_W'(sum >>> 30);
      if (&r[RND_W-1:COORD_BITS-1] || ~|r[RND_W-1:COORD_BITS-1]) begin
        rnd_res[c] = r[COORD_BITS-1:0];
        rnd_sat[c] = 1'b0;
      end else begin
        rnd_res[c] = r[RND_W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                : {1'b0, {(COORD_BITS-1){1'b1}}};
        rnd_sat[c] = 1'b1;
      end
    end
  end

  // next-state logic of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FN_READ && idx_ok) begin
            state_nxt = S_RD;
          end else if (in_ch.func == FN_POS || in_ch.func == FN_DU
                       || in_ch.func == FN_DV) begin
            state_nxt = S_BMUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD:   state_nxt = S_DONE;
      S_BMUL: state_nxt = S_BACC;
      S_BACC: state_nxt = (k_r + 3'd1 == n_cur) ? S_BSCL : S_BMUL;
      S_BSCL: state_nxt = S_BSTO;
      S_BSTO: state_nxt = (i_r == n_cur && axis_r) ? S_TRDA : S_BMUL;
      S_TRDA: state_nxt = S_TRDB;
      S_TRDB: state_nxt = S_TDIF;
      S_TDIF: state_nxt = S_MLO;
      S_MLO:  state_nxt = S_ALO;
      S_ALO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_AHI;
      S_AHI: begin
        if (c_r != 2'd2) begin
          state_nxt = S_MLO;
        end else if (i_r == nu && j_r == nv) begin
          state_nxt = S_SCL;
        end else begin
          state_nxt = S_TRDA;
        end
      end
      S_SCL:  state_nxt = S_RND;
      S_RND:  state_nxt = S_DONE;
      S_DONE: state_nxt = (!out_valid_r || out_ch.ready) ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // degree register and per-point valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEG_RST;
      valid_r  <= '0;
    end else if (cfg_acc && cfg_ch.degree >= 3'd2 && cfg_ch.degree <= 3'(MAX_DEGREE)) begin
      degree_r <= cfg_ch.degree;
      valid_r  <= '0;
    end else if (ram_we) begin
      valid_r[in_addr] <= 1'b1;
    end
  end

  // datapath registers, advanced by the sequencer
  always_ff @(posedge clk) begin
    rvalid_r <= valid_r[rd_addr];
    case (state_r)
      S_IDLE: begin
        func_r       <= in_ch.func;
        pu_r         <= (in_ch.param_u > PARAM_ONE) ? PARAM_ONE : in_ch.param_u;
        pv_r         <= (in_ch.param_v > PARAM_ONE) ? PARAM_ONE : in_ch.param_v;
        axis_r       <= 1'b0;
        i_r          <= '0;
        j_r          <= '0;
        k_r          <= '0;
        p_r          <= W_ONE;
        res_r[0]     <= '0;
        res_r[1]     <= '0;
        res_r[2]     <= '0;
        res_status_r <= ST_OK;
        if (in_ch.func == FN_WRITE || in_ch.func == FN_READ) begin
          res_status_r <= idx_ok ? ST_OK : ST_ERR;
        end else if (!(in_ch.func == FN_POS || in_ch.func == FN_DU
                       || in_ch.func == FN_DV)) begin
          res_status_r <= ST_ERR;
        end
      end
      S_RD: begin
        for (int c = 0; c < 3; c++) begin
          res_r[c] <= rd_word[c*COORD_BITS +: COORD_BITS];
        end
      end
      S_BACC: begin
        p_r <= MUL_W'((prod_r + PROD_W'(32768)) >> 16);
        k_r <= k_r + 3'd1;
      end
      S_BSTO: begin
        if (axis_r) begin
          bv_r[i_r] <= prod_r[MUL_W-1:0];
        end else begin
          bu_r[i_r] <= prod_r[MUL_W-1:0];
        end
        k_r <= '0;
        p_r <= W_ONE;
        if (i_r == n_cur) begin
          i_r    <= '0;
          axis_r <= 1'b1;
          acc_r[0] <= '0;
          acc_r[1] <= '0;
          acc_r[2] <= '0;
        end else begin
          i_r <= i_r + 3'd1;
        end
      end
      S_TRDB: begin
        a_r <= rd_word;
        w_r <= MUL_W'((prod_r + PROD_W'(W_ONE >> 1)) >> 30);
      end
      S_TDIF: begin
        for (int c = 0; c < 3; c++) begin
          if (func_r == FN_POS) begin
            d_r[c] <= D_W'($signed(a_r[c*COORD_BITS +: COORD_BITS]));
          end else begin
            d_r[c] <= D_W'($signed(a_r[c*COORD_BITS +: COORD_BITS]))
                    - D_W'($signed(rd_word[c*COORD_BITS +: COORD_BITS]));
          end
        end
        c_r <= 2'd0;
      end
      S_ALO: acc_r[c_r] <= acc_r[c_r] + term_lo;
      S_AHI: begin
        acc_r[c_r] <= acc_r[c_r] + term_hi;
        if (c_r != 2'd2) begin
          c_r <= c_r + 2'd1;
        end else if (i_r == nu) begin
          i_r <= '0;
          j_r <= j_r + 3'd1;
        end else begin
          i_r <= i_r + 3'd1;
        end
      end
      S_SCL: begin
        if (func_r != FN_POS) begin
          for (int c = 0; c < 3; c++) begin
            case (degree_r)
              3'd4:    acc_r[c] <= acc_r[c] <<< 2;
              3'd3:    acc_r[c] <= (acc_r[c] <<< 1) + acc_r[c];
              default: acc_r[c] <= acc_r[c] <<< 1;
            endcase
          end
        end
      end
      S_RND: begin
        for (int c = 0; c < 3; c++) begin
          res_r[c] <= rnd_res[c];
        end
        res_status_r <= (|rnd_sat) ? ST_SAT : ST_OK;
      end
      default: begin
      end
    endcase
  end

  // output register: load a finished result, hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_status_r <= res_status_r;
      out_r[0]     <= res_r[0];
      out_r[1]     <= res_r[1];
      out_r[2]     <= res_r[2];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.out_x  = out_r[0];
  assign out_ch.out_y  = out_r[1];
  assign out_ch.out_z  = out_r[2];

endmodule

// File: rtl/bse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bse_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/bse_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on bse_pkg for the operand width.
module bse_mul
  import bse_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod_r
);
  // register the product for use in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end
endmodule

// File: test/bezier_surface_evaluator_test.sv
// Self-checking bench for bezier_surface_evaluator: directed table, then random requests.
// Depends on bse_pkg, the bse_in_if/bse_out_if/bse_cfg_if interfaces and the block's RTL.
// Expected results: the directed table, or a bit-exact fixed-point surface predictor here.
module bezier_surface_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bse_pkg::*;

  typedef struct {
    logic [2:0]         func;
    logic [2:0]         ui;
    logic [2:0]         vi;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]        pu;
    logic [16:0]        pv;
  } request_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_res_t;

  typedef struct {
    request_t   req;
    bit         typed;
    point_res_t res;
  } table_row_t;

  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;

  bse_in_if  #(.COORD_BITS(32)) in_ch ();
  bse_out_if #(.COORD_BITS(32)) out_ch ();
  bse_cfg_if cfg_ch ();

  bezier_surface_evaluator #(.MAX_DEGREE(4), .COORD_BITS(32)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: degree and control grid, indexed [row v][column u][coord]
  int unsigned        cur_degree;
  logic signed [63:0] grid [5][5][3];
  int unsigned        choose [5][5] = '{'{1, 0, 0, 0, 0}, '{1, 1, 0, 0, 0}, '{1, 2, 1, 0, 0},
                                        '{1, 3, 3, 1, 0}, '{1, 4, 6, 4, 1}};

  point_res_t expected_q [$];
  table_row_t directed [$];
  int         errors;
  int         mismatches;
  int         snd_idle;
  int         rcv_idle;
  int         phase_no;
  logic       holding;

  // Clock and timeout watchdog
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void clear_grid();
    for (int j = 0; j < 5; j++)
      for (int i = 0; i < 5; i++)
        for (int c = 0; c < 3; c++) grid[j][i][c] = '0;
  endfunction

  // Bernstein weights in Q.30 for degree n at parameter t
  function automatic void bernstein(int unsigned n, logic [63:0] t, output logic [63:0] b [5]);
    logic [63:0] s;
    logic [63:0] p;
    s = 64'd65536 - t;
    for (int i = 0; i < 5; i++) b[i] = '0;
    for (int i = 0; i <= n; i++) begin
      p = 64'd1 << 30;
      for (int k = 0; k < i; k++) p = (p * t + 64'd32768) >> 16;
      for (int k = 0; k < n - i; k++) p = (p * s + 64'd32768) >> 16;
      b[i] = 64'(choose[n][i]) * p;
    end
  endfunction

  // Surface position (mode 0) or u/v partial derivative (mode 1/2); returns saturation flag
  function automatic bit surface_eval(int mode, logic [63:0] tu, logic [63:0] tv,
                                      output logic signed [31:0] r [3]);
    logic [63:0]         bu [5];
    logic [63:0]         bv [5];
    logic [63:0]         w;
    logic signed [127:0] acc;
    logic signed [127:0] d;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    int unsigned         nu;
    int unsigned         nv;
    bit                  sat;
    nu = cur_degree - (mode == 1 ? 1 : 0);
    nv = cur_degree - (mode == 2 ? 1 : 0);
    hi_lim = 128'(CMAX);
    lo_lim = 128'(CMIN);
    sat = 1'b0;
    bernstein(nu, tu, bu);
    bernstein(nv, tv, bv);
    for (int c = 0; c < 3; c++) begin
      acc = '0;
      for (int i = 0; i <= nu; i++) begin
        for (int j = 0; j <= nv; j++) begin
          w = (bu[i] * bv[j] + (64'd1 << 29)) >> 30;
          if (mode == 1) d = 128'(grid[j][i+1][c] - grid[j][i][c]);
          else if (mode == 2) d = 128'(grid[j+1][i][c] - grid[j][i][c]);
          else d = 128'(grid[j][i][c]);
          acc = acc + d * $signed({64'd0, w});
        end
      end
      if (mode != 0) acc = acc * $signed(128'(cur_degree));
      acc = (acc + $signed(128'd1 << 29)) >>> 30;
      if (acc > hi_lim) begin
        r[c] = CMAX;
        sat = 1'b1;
      end else if (acc < lo_lim) begin
        r[c] = CMIN;
        sat = 1'b1;
      end else begin
        r[c] = acc[31:0];
      end
    end
    return sat;
  endfunction

  // Work out the result of one request and update the grid
  function automatic point_res_t predict_result(request_t rq);
    point_res_t         res;
    logic signed [31:0] r [3];
    logic [63:0]        tu;
    logic [63:0]        tv;
    res = '{ST_OK, '0, '0, '0};
    tu = (rq.pu > PARAM_ONE) ? 64'd65536 : 64'(rq.pu);
    tv = (rq.pv > PARAM_ONE) ? 64'd65536 : 64'(rq.pv);
    if (rq.func == FN_WRITE || rq.func == FN_READ) begin
      if (rq.ui > cur_degree || rq.vi > cur_degree) begin
        res.status = ST_ERR;
      end else if (rq.func == FN_WRITE) begin
        grid[rq.vi][rq.ui][0] = 64'(rq.px);
        grid[rq.vi][rq.ui][1] = 64'(rq.py);
        grid[rq.vi][rq.ui][2] = 64'(rq.pz);
      end else begin
        res.x = grid[rq.vi][rq.ui][0][31:0];
        res.y = grid[rq.vi][rq.ui][1][31:0];
        res.z = grid[rq.vi][rq.ui][2][31:0];
      end
    end else if (rq.func == FN_POS || rq.func == FN_DU || rq.func == FN_DV) begin
      if (surface_eval(int'(rq.func) - int'(FN_POS), tu, tv, r)) res.status = ST_SAT;
      res.x = r[0];
      res.y = r[1];
      res.z = r[2];
    end else begin
      res.status = ST_ERR;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $signed(32'($urandom_range(2097152))) - 32'sd1048576;
      1: return $signed($urandom());
      2: return $urandom_range(1) ? CMAX : CMIN;
      3: return $signed(32'($urandom_range(20))) - 32'sd10;
      default: return $signed(32'($urandom_range(33554432))) - 32'sd16777216;
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return PARAM_ONE;
      2: return 17'($urandom_range(131071));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // Mostly well-formed traffic: fill the grid, read back, evaluate; some noise
  function automatic request_t rand_request();
    request_t    rq;
    int unsigned pick;
    pick = $urandom_range(99);
    rq.px = rand_coord();
    rq.py = rand_coord();
    rq.pz = rand_coord();
    rq.pu = rand_param();
    rq.pv = rand_param();
    rq.ui = 3'($urandom_range(cur_degree));
    rq.vi = 3'($urandom_range(cur_degree));
    if (pick < 35) rq.func = FN_WRITE;
    else if (pick < 48) rq.func = FN_READ;
    else if (pick < 62) rq.func = FN_POS;
    else if (pick < 76) rq.func = FN_DU;
    else if (pick < 90) rq.func = FN_DV;
    else if (pick < 95) begin
      rq.func = $urandom_range(1) ? FN_WRITE : FN_READ;
      rq.ui = 3'($urandom_range(7));
      rq.vi = 3'($urandom_range(7));
    end else begin
      rq.func = 3'($urandom_range(7, 5));
    end
    return rq;
  endfunction

  function automatic request_t mk(logic [2:0] f, int u, int v, logic signed [31:0] x,
                                  logic signed [31:0] y, logic signed [31:0] z,
                                  logic [16:0] pu, logic [16:0] pv);
    request_t rq;
    rq = '{f, 3'(u), 3'(v), x, y, z, pu, pv};
    return rq;
  endfunction

  function automatic void add_row(request_t rq, bit typed, logic [1:0] st,
                                  logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z);
    table_row_t row;
    row.req = rq;
    row.typed = typed;
    row.res = '{st, x, y, z};
    directed.push_back(row);
  endfunction

  // Offer one request, hold it until accepted, then record its expectation
  task automatic send_request(request_t rq, bit typed, point_res_t typed_res);
    point_res_t res;
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= rq.func;
    in_ch.u_index <= rq.ui;
    in_ch.v_index <= rq.vi;
    in_ch.point_x <= rq.px;
    in_ch.point_y <= rq.py;
    in_ch.point_z <= rq.pz;
    in_ch.param_u <= rq.pu;
    in_ch.param_v <= rq.pv;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_result(rq);
    expected_q.push_back(typed ? typed_res : res);
  endtask

  // Wait for the block to drain, then write the degree register
  task automatic write_degree(logic [2:0] value);
    in_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (10) @(posedge clk);
    cfg_ch.valid  <= 1'b1;
    cfg_ch.degree <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (value >= 3'd2 && value <= 3'd4) begin
      cur_degree = value;
      clear_grid();
    end
  endtask

  // Receiver: random back-pressure, or a long hold-off
  always @(posedge clk) begin
    out_ch.ready <= holding ? 1'b0 : ($urandom_range(99) >= rcv_idle);
  end

  // Long hold-off at the start of the fifth phase, so the input stalls
  initial begin
    holding = 1'b0;
    wait (phase_no == 4);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // Compare each result against the oldest expectation
  always @(posedge clk) begin
    point_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result status=%0d", out_ch.status);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.status !== want.status || out_ch.out_x !== want.x ||
            out_ch.out_y !== want.y || out_ch.out_z !== want.z) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp st=%0d %h %h %h, got st=%0d %h %h %h",
                     want.status, want.x, want.y, want.z,
                     out_ch.status, out_ch.out_x, out_ch.out_y, out_ch.out_z);
        end
      end
    end
  end

  // Main sequence
  initial begin
    logic [2:0] phase_degree [PHASES];
    phase_degree  = '{3'd4, 3'd2, 3'd7, 3'd3, 3'd1, 3'd4};
    in_ch.valid   = 1'b0;
    in_ch.func    = FN_WRITE;
    in_ch.u_index = '0;
    in_ch.v_index = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.param_u = '0;
    in_ch.param_v = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.degree = 3'd3;
    out_ch.ready  = 1'b0;
    errors = 0;
    mismatches = 0;
    phase_no = -1;
    snd_idle = 35;
    rcv_idle = 45;
    cur_degree = 3;
    clear_grid();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset degree
    add_row(mk(FN_READ, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0, 0, 0);
    add_row(mk(FN_READ, 3, 3, 0, 0, 0, 0, 0), 1, ST_OK, 0, 0, 0);
    add_row(mk(FN_READ, 4, 0, 0, 0, 0, 0, 0), 1, ST_ERR, 0, 0, 0);
    add_row(mk(FN_WRITE, 0, 7, CMAX, CMAX, CMAX, 0, 0), 1, ST_ERR, 0, 0, 0);
    add_row(mk(3'd5, 7, 7, -1, -1, -1, 17'h1ffff, 17'h1ffff), 1, ST_ERR, 0, 0, 0);
    add_row(mk(3'd6, 0, 0, 0, 0, 0, 0, 0), 1, ST_ERR, 0, 0, 0);
    add_row(mk(3'd7, 1, 1, 0, 0, 0, 0, 0), 1, ST_ERR, 0, 0, 0);
    add_row(mk(FN_WRITE, 0, 0, CMAX, CMIN, -1, 0, 0), 1, ST_OK, 0, 0, 0);
    add_row(mk(FN_READ, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, CMAX, CMIN, -1);
    add_row(mk(FN_WRITE, 3, 3, CMIN, CMAX, 0, 0, 0), 1, ST_OK, 0, 0, 0);
    add_row(mk(FN_READ, 3, 3, 0, 0, 0, 0, 0), 1, ST_OK, CMIN, CMAX, 0);
    add_row(mk(FN_POS, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, CMAX, CMIN, -1);
    add_row(mk(FN_POS, 0, 0, 0, 0, 0, PARAM_ONE, PARAM_ONE), 1, ST_OK, CMIN, CMAX, 0);
    add_row(mk(FN_POS, 0, 0, 0, 0, 0, 17'h1ffff, 17'h1ffff), 1, ST_OK, CMIN, CMAX, 0);
    add_row(mk(FN_DU, 0, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0, 0, 0);
    add_row(mk(FN_DV, 0, 0, 0, 0, 0, 17'd32768, 17'd32768), 0, ST_OK, 0, 0, 0);
    add_row(mk(FN_DU, 0, 0, 0, 0, 0, PARAM_ONE, PARAM_ONE), 0, ST_OK, 0, 0, 0);
    add_row(mk(FN_DV, 0, 0, 0, 0, 0, 0, PARAM_ONE), 0, ST_OK, 0, 0, 0);
    add_row(mk(FN_WRITE, 1, 0, CMAX, CMAX, CMAX, 0, 0), 1, ST_OK, 0, 0, 0);
    add_row(mk(FN_DU, 0, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0, 0, 0);
    add_row(mk(FN_POS, 0, 0, 0, 0, 0, 17'd32768, 17'd21845), 0, ST_OK, 0, 0, 0);
    add_row(mk(FN_WRITE, 2, 1, 32'sd65536, -32'sd131072, 32'sd7, 0, 0), 1, ST_OK, 0, 0, 0);
    add_row(mk(FN_DV, 0, 0, 0, 0, 0, 17'd1, 17'd65535), 0, ST_OK, 0, 0, 0);
    foreach (directed[k]) send_request(directed[k].req, directed[k].typed, directed[k].res);

    // Random phases over several degrees and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      write_degree(phase_degree[p]);
      if (p < 2) begin
        snd_idle = 35;
        rcv_idle = 45;
      end else if (p < 4) begin
        snd_idle = 45;
        rcv_idle = 35;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      phase_no = p;
      for (int k = 0; k < PHASE_ITEMS; k++) send_request(rand_request(), 0, '{0, 0, 0, 0});
    end

    // Drain and report
    in_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/bse_pkg.sv
rtl/bse_in_if.sv
rtl/bse_out_if.sv
rtl/bse_cfg_if.sv
rtl/bse_ram.sv
rtl/bse_mul.sv
rtl/bezier_surface_evaluator.sv
test/bezier_surface_evaluator_test.sv
